// File: hdl/lru_byte_budget_cache_policy_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the cache policy RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_BYTE_BUDGET_CACHE_POLICY_CORE_MACROS_SVH
`define LRU_BYTE_BUDGET_CACHE_POLICY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBB_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("lbb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("lbb assertion failed");

`endif

// File: hdl/lbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbb_pkg
// Sizes, codes and shared types of the LRU byte budget cache policy.
// ----------------------------------------------------------------------------
package lbb_pkg;

    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 32;

    localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int SIZE_W = 32;
    localparam int WORD_W = KEY_W + SIZE_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = 1'b1;

    localparam logic [4:0]  ENTRY_LIMIT_RST = 5'd16;
    localparam logic [31:0] BYTE_BUDGET_RST = 32'd1048576;

    localparam logic [2:0] STAT_HIT    = 3'd0;
    localparam logic [2:0] STAT_MISS   = 3'd1;
    localparam logic [2:0] STAT_BYPASS = 3'd2;
    localparam logic [2:0] STAT_RANGE  = 3'd3;
    localparam logic [2:0] STAT_EVICT  = 3'd4;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_EVICT  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
    } t_rank_cmd;

    typedef struct packed {
        logic             slot_valid;
        logic [IDX_W-1:0] victim;
    } t_rank_stat;

endpackage

// File: hdl/lru_byte_budget_cache_policy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_policy_core
// LRU cache replacement policy with an entry limit and a byte budget.
// ----------------------------------------------------------------------------
// Each input word is one read request (key, object size, range offset and
// length); the block answers with one or more output words and marks the
// final one with last. The block works on one request at a time and drops
// in_ready from the accept cycle until the request's work is done. The
// key search walks the slots one per cycle through the read port of the
// slot RAM and a single key comparator, and each eviction needs one read
// of that RAM. Stalls on the output channel hold the sequencer in any
// state that loads a result. A finished result waits in the output register
// while the next request is accepted. Configuration is written through its
// own channel, which is always ready; index 0 is the entry limit (0 acts as
// 1, values above SLOTS act as SLOTS) and index 1 the byte budget. Both must
// be written only while no request is in flight.
// ----------------------------------------------------------------------------
`include "lru_byte_budget_cache_policy_core_macros.svh"

module lru_byte_budget_cache_policy_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_object_key,
    input  logic [31:0]                   i_object_size,
    input  logic [31:0]                   i_range_offset,
    input  logic [31:0]                   i_range_length,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_status,
    output logic [31:0]                   o_evicted_key,
    output logic [31:0]                   o_held_bytes,
    output logic [4:0]                    o_held_entries,
    output logic                          o_last,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_EVICT  = 3'd5;
    localparam logic [2:0] S_INSERT = 3'd6;

    localparam int IDX_W = lbb_pkg::IDX_W;
    localparam int CNT_W = lbb_pkg::CNT_W;
    localparam int KEY_W = lbb_pkg::KEY_W;
    localparam int LIM_W = lbb_pkg::LIM_W;

    logic [2:0]        r_state, n_state;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_off, n_off;
    logic [31:0]       r_len, n_len;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic              r_free_vld, n_free_vld;
    logic [IDX_W-1:0]  r_free, n_free;
    logic [IDX_W-1:0]  r_vic, n_vic;
    logic [31:0]       r_total, n_total;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [4:0]        r_limit, n_limit;
    logic [31:0]       r_budget, n_budget;

    logic              r_out_vld, n_out_vld;
    logic [2:0]        r_status, n_status;
    logic [31:0]       r_evkey, n_evkey;
    logic [31:0]       r_bytes, n_bytes;
    logic [4:0]        r_entries, n_entries;
    logic              r_last, n_last;

    // Slot RAM holds key and size side by side.
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [lbb_pkg::WORD_W-1:0] ram_rdata;
    logic [KEY_W-1:0]          rd_key;
    logic [31:0]               rd_size;

    lbb_pkg::t_rank_cmd  rank_cmd;
    lbb_pkg::t_rank_stat rank_stat;
    logic [IDX_W-1:0]    map_addr;

    logic              can_emit;
    logic              range_bad;
    logic [LIM_W-1:0]  eff_limit;
    logic              over_limit;
    logic              over_budget;
    logic [IDX_W-1:0]  scan_slot;

    lbb_ram #(
        .WIDTH (lbb_pkg::WORD_W),
        .DEPTH (lbb_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free),
        .i_wdata ({r_key, r_size}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lbb_rank_tbl u_rank_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (rank_cmd),
        .i_map_addr (map_addr),
        .o_stat     (rank_stat)
    );

    assign rd_key  = ram_rdata[lbb_pkg::WORD_W-1 -: KEY_W];
    assign rd_size = ram_rdata[31:0];

    // A result can be loaded when the output register is empty or drains now.
    assign can_emit = !r_out_vld || i_out_ready;

    // The offset test guards the subtraction, so size - offset never wraps.
    assign range_bad = (r_off > r_size) || (r_len > (r_size - r_off));

    assign eff_limit  = (LIM_W'(r_limit) > LIM_W'(lbb_pkg::SLOTS)) ?
                        LIM_W'(lbb_pkg::SLOTS) : LIM_W'(r_limit);
    assign over_limit = LIM_W'(r_count) >= eff_limit;
    assign over_budget = ({1'b0, r_total} + {1'b0, r_size}) > {1'b0, r_budget};

    // The least recent entry always holds rank count - 1.
    assign map_addr  = IDX_W'(r_count - 1'b1);
    assign scan_slot = IDX_W'(r_idx - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_size     = r_size;
        n_off      = r_off;
        n_len      = r_len;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free_vld = r_free_vld;
        n_free     = r_free;
        n_vic      = r_vic;
        n_total    = r_total;
        n_count    = r_count;
        n_limit    = r_limit;
        n_budget   = r_budget;
        n_out_vld  = r_out_vld;
        n_status   = r_status;
        n_evkey    = r_evkey;
        n_bytes    = r_bytes;
        n_entries  = r_entries;
        n_last     = r_last;
        ram_we     = 1'b0;
        ram_raddr  = r_vic;
        rank_cmd.op  = lbb_pkg::OP_NOP;
        rank_cmd.idx = '0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbb_pkg::REG_ENTRY_LIMIT: n_limit  = i_cfg_data[4:0];
                lbb_pkg::REG_BYTE_BUDGET: n_budget = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = KEY_W'(i_object_key);
                    n_size  = i_object_size;
                    n_off   = i_range_offset;
                    n_len   = i_range_length;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (range_bad) begin
                    if (can_emit) begin
                        n_out_vld = 1'b1;
                        n_status  = lbb_pkg::STAT_RANGE;
                        n_evkey   = '0;
                        n_bytes   = r_total;
                        n_entries = 5'(r_count);
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_free_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read slot r_idx while judging slot r_idx - 1 from the RAM output.
                ram_raddr = IDX_W'(r_idx);
                if (r_idx != '0) begin
                    rank_cmd.op  = lbb_pkg::OP_SCAN;
                    rank_cmd.idx = scan_slot;
                    if (rank_stat.slot_valid) begin
                        if ((rd_key == r_key) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = scan_slot;
                        end
                    end else if (!r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free     = scan_slot;
                    end
                end
                if (r_idx == CNT_W'(lbb_pkg::SLOTS)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
            end
            S_DECIDE: begin
                if (r_hit) begin
                    if (can_emit) begin
                        rank_cmd.op  = lbb_pkg::OP_TOUCH;
                        rank_cmd.idx = r_hit_idx;
                        n_out_vld = 1'b1;
                        n_status  = lbb_pkg::STAT_HIT;
                        n_evkey   = '0;
                        n_bytes   = r_total;
                        n_entries = 5'(r_count);
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (r_size > r_budget) begin
                    if (can_emit) begin
                        n_out_vld = 1'b1;
                        n_status  = lbb_pkg::STAT_BYPASS;
                        n_evkey   = '0;
                        n_bytes   = r_total;
                        n_entries = 5'(r_count);
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if ((r_count != '0) && (over_limit || over_budget)) begin
                    n_vic     = rank_stat.victim;
                    ram_raddr = rank_stat.victim;
                    n_state   = S_EVICT;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_EVICT: begin
                if (can_emit) begin
                    rank_cmd.op  = lbb_pkg::OP_EVICT;
                    rank_cmd.idx = r_vic;
                    n_total = r_total - rd_size;
                    n_count = CNT_W'(r_count - 1'b1);
                    // The lowest free slot is the one the insert will take.
                    if (!r_free_vld || (r_vic < r_free)) begin
                        n_free_vld = 1'b1;
                        n_free     = r_vic;
                    end
                    n_out_vld = 1'b1;
                    n_status  = lbb_pkg::STAT_EVICT;
                    n_evkey   = 32'(rd_key);
                    n_bytes   = n_total;
                    n_entries = 5'(n_count);
                    n_last    = 1'b0;
                    n_state   = S_EVAL;
                end
            end
            S_INSERT: begin
                if (can_emit) begin
                    ram_we       = 1'b1;
                    rank_cmd.op  = lbb_pkg::OP_INSERT;
                    rank_cmd.idx = r_free;
                    n_total = r_total + r_size;
                    n_count = CNT_W'(r_count + 1'b1);
                    n_out_vld = 1'b1;
                    n_status  = lbb_pkg::STAT_MISS;
                    n_evkey   = '0;
                    n_bytes   = n_total;
                    n_entries = 5'(n_count);
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_count   <= '0;
            r_limit   <= lbb_pkg::ENTRY_LIMIT_RST;
            r_budget  <= lbb_pkg::BYTE_BUDGET_RST;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_count   <= n_count;
            r_limit   <= n_limit;
            r_budget  <= n_budget;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_size     <= n_size;
        r_off      <= n_off;
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free_vld <= n_free_vld;
        r_free     <= n_free;
        r_vic      <= n_vic;
        r_status   <= n_status;
        r_evkey    <= n_evkey;
        r_bytes    <= n_bytes;
        r_entries  <= n_entries;
        r_last     <= n_last;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_evicted_key  = r_evkey;
    assign o_held_bytes   = r_bytes;
    assign o_held_entries = r_entries;
    assign o_last         = r_last;

    // An insert always has a free slot to take.
    `LBB_ASSERT_NOW(a_insert_has_free, i_clk, i_rst_n, r_state == S_INSERT, r_free_vld)
    // Evictions only happen while something is held.
    `LBB_ASSERT_NOW(a_evict_nonempty, i_clk, i_rst_n, r_state == S_EVICT, r_count != '0)
    // The occupancy never exceeds the slot count.
    `LBB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(lbb_pkg::SLOTS))
    // An empty cache holds no bytes.
    `LBB_ASSERT_NOW(a_empty_no_bytes, i_clk, i_rst_n, r_count == '0, r_total == '0)
    // Each eviction result lowers the occupancy by one.
    `LBB_ASSERT_NEXT(a_evict_drops, i_clk, i_rst_n, (r_state == S_EVICT) && can_emit,
        r_count == CNT_W'($past(r_count) - 1'b1))

endmodule

// File: hdl/lbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbb_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lbb_rank_tbl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbb_rank_tbl
// Slot valid bits, recency ranks and the rank-to-slot map used for eviction.
// ----------------------------------------------------------------------------
module lbb_rank_tbl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lbb_pkg::t_rank_cmd        i_cmd,
    input  logic [lbb_pkg::IDX_W-1:0] i_map_addr,
    output lbb_pkg::t_rank_stat       o_stat
);

    logic [lbb_pkg::SLOTS-1:0] r_valid;
    logic [lbb_pkg::SLOTS-1:0] n_valid;
    logic [lbb_pkg::IDX_W-1:0] r_rank [lbb_pkg::SLOTS];
    logic [lbb_pkg::IDX_W-1:0] n_rank [lbb_pkg::SLOTS];
    logic [lbb_pkg::IDX_W-1:0] r_map  [lbb_pkg::SLOTS];
    logic [lbb_pkg::IDX_W-1:0] sel_rank;

    assign sel_rank = r_rank[i_cmd.idx];

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        unique case (i_cmd.op)
            lbb_pkg::OP_TOUCH: begin
                // Entries more recent than the touched one age by one step.
                for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                    if (r_valid[i] && (r_rank[i] < sel_rank)) begin
                        n_rank[i] = lbb_pkg::IDX_W'(r_rank[i] + 1'b1);
                    end
                end
                n_rank[i_cmd.idx] = '0;
            end
            lbb_pkg::OP_EVICT: begin
                n_valid[i_cmd.idx] = 1'b0;
            end
            lbb_pkg::OP_INSERT: begin
                for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                    if (r_valid[i]) begin
                        n_rank[i] = lbb_pkg::IDX_W'(r_rank[i] + 1'b1);
                    end
                end
                n_valid[i_cmd.idx] = 1'b1;
                n_rank[i_cmd.idx]  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // Ranks of valid slots are distinct, so the scan fills one map entry per rank.
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == lbb_pkg::OP_SCAN) && r_valid[i_cmd.idx]) begin
            r_map[sel_rank] <= i_cmd.idx;
        end
    end

    assign o_stat.slot_valid = r_valid[i_cmd.idx];
    assign o_stat.victim     = r_map[i_map_addr];

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the LRU byte budget cache policy core.
// ----------------------------------------------------------------------------
// The bench drives read requests into the core and keeps its own model of
// the slot table: keys, sizes, recency ranks, held bytes and held entries.
// Each accepted request word is turned into the list of result words that
// the core must produce: evictions in recency order, then the final status
// word. Every result word taken from the core is compared field by field with
// the oldest outstanding prediction. A directed opening covers the corner
// cases. Random phases follow, each with its own entry limit and byte budget.
// ----------------------------------------------------------------------------
module tb;

    // A run that goes this many cycles without any handshake is hung.
    localparam int HANG_LIMIT = 4000;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 60;
    localparam int POOL_DEPTH = 24;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] evicted_key;
        logic [31:0] held_bytes;
        logic [4:0]  held_entries;
        logic        last;
    } t_policy_result;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the slot table and the queue of result words
    // that the core still owes.
    // ------------------------------------------------------------------------
    class cache_policy_scoreboard;
        logic [31:0]    slot_key [lbb_pkg::SLOTS];
        logic [31:0]    slot_size [lbb_pkg::SLOTS];
        bit             slot_valid [lbb_pkg::SLOTS];
        int unsigned    slot_rank [lbb_pkg::SLOTS];
        logic [31:0]    held_bytes;
        int unsigned    held_entries;
        logic [4:0]     entry_limit;
        logic [31:0]    byte_budget;
        t_policy_result owed_q [$];
        int             failures;

        function void reset_state();
            for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            held_bytes   = '0;
            held_entries = 0;
            entry_limit  = lbb_pkg::ENTRY_LIMIT_RST;
            byte_budget  = lbb_pkg::BYTE_BUDGET_RST;
            owed_q.delete();
            failures     = 0;
        endfunction

        function void write_reg(logic [lbb_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
            if (index == lbb_pkg::REG_ENTRY_LIMIT)
                entry_limit = data[4:0];
            else if (index == lbb_pkg::REG_BYTE_BUDGET)
                byte_budget = data;
        endfunction

        function void owe(logic [2:0] status, logic [31:0] key, logic last);
            t_policy_result r;
            r.status       = status;
            r.evicted_key  = key;
            r.held_bytes   = held_bytes;
            r.held_entries = held_entries[4:0];
            r.last         = last;
            owed_q.push_back(r);
        endfunction

        // Works out every result word that one accepted request causes.
        function void note_request(logic [31:0] key_in, logic [31:0] obj_size,
                                   logic [31:0] offset, logic [31:0] length);
            logic [31:0] key;
            logic [31:0] key_mask;
            int          hit_slot;
            int          victim;
            int unsigned worst;
            int unsigned cap;
            int unsigned r;

            key_mask = (lbb_pkg::KEY_W >= 32) ? 32'hFFFF_FFFF :
                       ((32'd1 << lbb_pkg::KEY_W) - 32'd1);
            key      = key_in & key_mask;
            hit_slot = -1;

            // The range test is done without wrap: offset first, then the
            // length against what is left of the object.
            if (offset > obj_size || length > obj_size - offset) begin
                owe(lbb_pkg::STAT_RANGE, '0, 1'b1);
                return;
            end

            for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key)
                    hit_slot = i;
            end

            if (hit_slot >= 0) begin
                r = slot_rank[hit_slot];
                for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                    if (slot_valid[i] && slot_rank[i] < r)
                        slot_rank[i]++;
                end
                slot_rank[hit_slot] = 0;
                owe(lbb_pkg::STAT_HIT, '0, 1'b1);
                return;
            end

            if (obj_size > byte_budget) begin
                owe(lbb_pkg::STAT_BYPASS, '0, 1'b1);
                return;
            end

            // A limit of zero empties the table; above the slot count it
            // saturates.
            cap = (entry_limit > lbb_pkg::SLOTS) ? lbb_pkg::SLOTS : entry_limit;
            while (held_entries > 0 &&
                   (held_entries >= cap ||
                    33'(held_bytes) + 33'(obj_size) > 33'(byte_budget))) begin
                victim = -1;
                worst  = 0;
                for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                    if (slot_valid[i] && (victim < 0 || slot_rank[i] > worst)) begin
                        victim = i;
                        worst  = slot_rank[i];
                    end
                end
                slot_valid[victim] = 1'b0;
                held_bytes = (held_bytes >= slot_size[victim]) ?
                             held_bytes - slot_size[victim] : '0;
                held_entries--;
                owe(lbb_pkg::STAT_EVICT, slot_key[victim], 1'b0);
            end

            for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                if (slot_valid[i])
                    slot_rank[i]++;
            end
            for (int i = 0; i < lbb_pkg::SLOTS; i++) begin
                if (!slot_valid[i]) begin
                    slot_valid[i] = 1'b1;
                    slot_key[i]   = key;
                    slot_size[i]  = obj_size;
                    slot_rank[i]  = 0;
                    held_bytes    = held_bytes + obj_size;
                    held_entries++;
                    break;
                end
            end
            owe(lbb_pkg::STAT_MISS, '0, 1'b1);
        endfunction

        function void check_result(logic [2:0] status, logic [31:0] evicted_key,
                                   logic [31:0] bytes_now, logic [4:0] entries_now,
                                   logic last);
            t_policy_result w;
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: status %0d key %h bytes %0d",
                             status, evicted_key, bytes_now);
                return;
            end
            w = owed_q.pop_front();
            if (status !== w.status || evicted_key !== w.evicted_key ||
                bytes_now !== w.held_bytes || entries_now !== w.held_entries ||
                last !== w.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("result mismatch (got/wanted): status %0d/%0d key %h/%h",
                             status, w.status, evicted_key, w.evicted_key);
                    $display("    bytes %0d/%0d entries %0d/%0d last %0d/%0d",
                             bytes_now, w.held_bytes, entries_now, w.held_entries,
                             last, w.last);
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the core starts at a known value.
    // ------------------------------------------------------------------------
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [31:0]                   i_object_key   = '0;
    logic [31:0]                   i_object_size  = '0;
    logic [31:0]                   i_range_offset = '0;
    logic [31:0]                   i_range_length = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic [2:0]                    o_status;
    logic [31:0]                   o_evicted_key;
    logic [31:0]                   o_held_bytes;
    logic [4:0]                    o_held_entries;
    logic                          o_last;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [lbb_pkg::CFG_IDX_W-1:0] i_cfg_index    = lbb_pkg::REG_ENTRY_LIMIT;
    logic [31:0]                   i_cfg_data     = '0;

    cache_policy_scoreboard sb;

    // Random phase state: key pool, current budget and the no-idle flag.
    logic [31:0] key_pool [POOL_DEPTH];
    int          pool_used  = POOL_DEPTH;
    logic [31:0] budget_now = lbb_pkg::BYTE_BUDGET_RST;
    bit          calm       = 1'b0;
    int          quiet_cycles = 0;

    // Per-phase settings; the extremes of both registers are in the list.
    // The seventh phase draws its own values at random.
    logic [4:0]  phase_limit  [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                          5'd4, 5'd17, 5'd0, 5'd8};
    logic [31:0] phase_budget [PHASES] = '{32'd4096, 32'd1, 32'd100000,
                                          32'hFFFF_FFFF, 32'd5000, 32'd65536,
                                          32'd0, 32'd1000};
    int          phase_pool   [PHASES] = '{24, 6, 8, 24, 10, 20, 16, 12};

    lru_byte_budget_cache_policy_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_object_key   (i_object_key),
        .i_object_size  (i_object_size),
        .i_range_offset (i_range_offset),
        .i_range_length (i_range_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_evicted_key  (o_evicted_key),
        .o_held_bytes   (o_held_bytes),
        .o_held_entries (o_held_entries),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The result side backs off about eight times in a hundred, except
    // during the calm phase, where it is always ready.
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99, 0) >= 8);
    end

    // Result words are sampled at the edge where they are taken, so the
    // values seen are the ones that stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_evicted_key, o_held_bytes, o_held_entries,
                            o_last);
    end

    // Hang detector: any handshake on any channel restarts the count. The
    // slowest request (sixteen evictions, each result stalled) stays far
    // below the limit.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("lru_byte_budget_cache_policy_core regression: fail");
            $finish;
        end
    end

    // Presents one request word and holds it until the core takes it. Valid
    // is only lowered while idling, so back-to-back words keep it high
    // without a second assignment in the same step.
    task automatic send_request(input logic [31:0] key, input logic [31:0] obj_size,
                                input logic [31:0] offset, input logic [31:0] length);
        while (!calm && $urandom_range(99, 0) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_object_key   <= key;
        i_object_size  <= obj_size;
        i_range_offset <= offset;
        i_range_length <= length;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(key, obj_size, offset, length);
    endtask

    // Writes both registers back to back, keeping valid high across them.
    task automatic configure(input logic [4:0] limit, input logic [31:0] budget);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lbb_pkg::REG_ENTRY_LIMIT;
        i_cfg_data  <= {27'd0, limit};
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(lbb_pkg::REG_ENTRY_LIMIT, {27'd0, limit});
        i_cfg_index <= lbb_pkg::REG_BYTE_BUDGET;
        i_cfg_data  <= budget;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(lbb_pkg::REG_BYTE_BUDGET, budget);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every owed result word has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Registers may only change with no request in flight, so the sender
    // pauses until the core has caught up, then lets it settle briefly.
    task automatic reconfigure(input logic [4:0] limit, input logic [31:0] budget);
        drain();
        repeat (4) @(posedge i_clk);
        configure(limit, budget);
    endtask

    // One random request. Most are well formed and draw keys from a small
    // pool so that hits and evictions are common; sizes scale with the
    // budget, with some empty, oversized and full-width objects mixed in.
    // A share of the ranges is broken on purpose.
    task automatic random_request();
        logic [31:0] key;
        logic [31:0] obj_size;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] cap;
        int          roll;

        key  = key_pool[$urandom_range(pool_used - 1, 0)];
        cap  = (budget_now < 3) ? 32'd1 : budget_now / 3;
        roll = $urandom_range(99, 0);
        if (roll < 4)
            obj_size = '0;
        else if (roll < 10 && budget_now != 32'hFFFF_FFFF)
            obj_size = $urandom_range(32'hFFFF_FFFF, budget_now + 32'd1);
        else if (roll < 14)
            obj_size = $urandom();
        else
            obj_size = $urandom_range(cap, 1);

        offset = $urandom_range(obj_size, 0);
        if ($urandom_range(3, 0) == 0)
            length = obj_size - offset;
        else
            length = $urandom_range(obj_size - offset, 0);

        roll = $urandom_range(99, 0);
        if (roll < 7 && obj_size != 32'hFFFF_FFFF) begin
            // Offset past the end of the object.
            offset = $urandom_range(32'hFFFF_FFFF, obj_size + 32'd1);
            length = $urandom();
        end else if (roll < 14 && obj_size - offset != 32'hFFFF_FFFF) begin
            // Length running past the end of the object.
            length = $urandom_range(32'hFFFF_FFFF, obj_size - offset + 32'd1);
        end
        send_request(key, obj_size, offset, length);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed opening, at the reset settings ----
        // Offset past the end, then length past the end.
        send_request(32'h0000_0000, 32'd100, 32'd101, 32'd0);
        send_request(32'h0000_0001, 32'd100, 32'd50, 32'd51);
        // Empty range right at the end of the object is legal: miss.
        send_request(32'h0000_0000, 32'd100, 32'd100, 32'd0);
        // Full-width objects above the budget are bypassed.
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        // A hit that names a different size leaves the held entry alone.
        send_request(32'h0000_0000, 32'd7, 32'd0, 32'd7);
        // An empty object is cached with zero bytes.
        send_request(32'h0000_0005, 32'd0, 32'd0, 32'd0);
        // Fill the table; the last one pushes out the oldest entry.
        for (int i = 0; i < 15; i++)
            send_request(32'hA5A5_0000 + i, 32'd65536, 32'd0, 32'd1);
        send_request(32'h0000_0005, 32'd0, 32'd0, 32'd0);

        // A limit of zero empties the whole table before the insert.
        reconfigure(5'd0, lbb_pkg::BYTE_BUDGET_RST);
        send_request(32'h5A5A_5A5A, 32'd3, 32'd1, 32'd2);

        // Limit above the slot count, widest budget, widest object.
        reconfigure(5'd31, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(32'h0000_0002, 32'd1, 32'd0, 32'd1);
        send_request(32'h0000_0003, 32'd1000, 32'd0, 32'd1000);
        send_request(32'h0000_0004, 32'd1000, 32'd999, 32'd1);

        // Budget dropped below what is held: evictions continue until the
        // new object fits.
        reconfigure(5'd16, 32'd1500);
        send_request(32'h0000_0006, 32'd10, 32'd0, 32'd10);

        // ---- Random phases ----
        for (int p = 0; p < PHASES; p++) begin
            if (p == 6)
                reconfigure(5'($urandom_range(31, 0)), $urandom_range(32'hFFFF_FFFF, 1));
            else
                reconfigure(phase_limit[p], phase_budget[p]);
            budget_now = sb.byte_budget;
            pool_used  = phase_pool[p];
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            for (int k = 2; k < POOL_DEPTH; k++)
                key_pool[k] = $urandom();
            // One phase runs with neither side idling.
            calm = (p == 3);
            repeat (PHASE_REQS) random_request();
        end
        calm = 1'b0;

        drain();
        repeat (2 * lbb_pkg::SLOTS + 16) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("lru_byte_budget_cache_policy_core regression: pass");
        else
            $display("lru_byte_budget_cache_policy_core regression: fail");
        $finish;
    end

endmodule
